@@ sv/tilt_rotation_light_control_macros.svh @@
// Assertion macros shared by the tilt and rotation light control RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef TILT_ROTATION_LIGHT_CONTROL_MACROS_SVH
`define TILT_ROTATION_LIGHT_CONTROL_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlc: same-cycle check failed");
`define TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlc: next-cycle check failed");
`else
`define TLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/tlc_pkg.sv @@
// Shared types and constants for the tilt and rotation light control.
// No dependencies; imported by every module of the block.
package tlc_pkg;

	localparam int AngleW  = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_BRIGHTNESS_GAIN   = 3'd0;
	localparam cfg_idx_t REG_HUE_GAIN          = 3'd1;
	localparam cfg_idx_t REG_SATURATION_GAIN   = 3'd2;
	localparam cfg_idx_t REG_DEAD_ZONE         = 3'd3;
	localparam cfg_idx_t REG_LEVEL_LIMIT       = 3'd4;
	localparam cfg_idx_t REG_FLIP_LIMIT        = 3'd5;
	localparam cfg_idx_t REG_SLEEP_DELAY_TICKS = 3'd6;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_STANDING    = 2'd0;
	localparam mode_t MODE_LYING       = 2'd1;
	localparam mode_t MODE_UPSIDE_DOWN = 2'd2;

	typedef struct packed {
		logic [7:0]  brightness_gain;
		logic [7:0]  hue_gain;
		logic [7:0]  saturation_gain;
		logic [7:0]  dead_zone;
		logic [11:0] level_limit;
		logic [11:0] flip_limit;
		logic [15:0] sleep_delay_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		brightness_gain:   8'd12,
		hue_gain:          8'd6,
		saturation_gain:   8'd12,
		dead_zone:         8'd3,
		level_limit:       12'd720,
		flip_limit:        12'd2400,
		sleep_delay_ticks: 16'd100
	};

	typedef struct packed {
		logic [7:0] brightness;
		logic [7:0] hue;
		logic [7:0] saturation;
	} levels_t;

	localparam levels_t LEVELS_RESET = '{
		brightness: 8'd128,
		hue:        8'd32,
		saturation: 8'd200
	};

endpackage

@@ sv/tlc_cfg.sv @@
// Configuration register file of the tilt and rotation light control.
// Depends on tlc_pkg for the register indexes and the cfg_t layout.
module tlc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  tlc_pkg::cfg_idx_t wr_idx,
	input  logic [15:0]       wr_data,
	output tlc_pkg::cfg_t     cfg
);
	import tlc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				REG_BRIGHTNESS_GAIN:   cfg_q.brightness_gain   <= wr_data[7:0];
				REG_HUE_GAIN:          cfg_q.hue_gain          <= wr_data[7:0];
				REG_SATURATION_GAIN:   cfg_q.saturation_gain   <= wr_data[7:0];
				REG_DEAD_ZONE:         cfg_q.dead_zone         <= wr_data[7:0];
				REG_LEVEL_LIMIT:       cfg_q.level_limit       <= wr_data[11:0];
				REG_FLIP_LIMIT:        cfg_q.flip_limit        <= wr_data[11:0];
				REG_SLEEP_DELAY_TICKS: cfg_q.sleep_delay_ticks <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/tlc_pose.sv @@
// Pose classifier: standing, lying or upside down from the x and y tilt.
// Depends on tlc_pkg for the mode codes.
module tlc_pose (
	input  logic [15:0]    tilt_x,
	input  logic [15:0]    tilt_y,
	input  logic [11:0]    level_limit,
	input  logic [11:0]    flip_limit,
	output tlc_pkg::mode_t mode
);
	import tlc_pkg::*;

	logic [15:0] abs_x;
	logic [15:0] abs_y;
	logic        x_level;
	logic        y_level;
	logic        x_flipped;

	assign abs_x     = tilt_x[15] ? (16'd0 - tilt_x) : tilt_x;
	assign abs_y     = tilt_y[15] ? (16'd0 - tilt_y) : tilt_y;
	assign x_level   = abs_x < {4'd0, level_limit};
	assign y_level   = abs_y < {4'd0, level_limit};
	assign x_flipped = abs_x > {4'd0, flip_limit};

	always_comb begin
		if (x_level && y_level) begin
			mode = MODE_UPSIDE_DOWN;
		end else if (x_flipped && y_level) begin
			mode = MODE_STANDING;
		end else begin
			mode = MODE_LYING;
		end
	end

endmodule

@@ sv/tlc_update.sv @@
// Level update: scales the yaw change by the gain of the pose and applies it.
// Depends on tlc_pkg for cfg_t, levels_t and the mode codes.
module tlc_update #(
	parameter int FRAC_BITS = 4
) (
	input  tlc_pkg::cfg_t    cfg,
	input  tlc_pkg::mode_t   mode,
	input  logic [15:0]      yaw,
	input  logic [15:0]      prev_yaw,
	input  logic             prev_valid,
	input  tlc_pkg::levels_t levels,
	output tlc_pkg::levels_t levels_next
);
	import tlc_pkg::*;

	logic signed [16:0] diff;
	logic        [16:0] diff_neg;
	logic               neg;
	logic        [15:0] mag;
	logic        [7:0]  gain;
	logic        [23:0] prod;
	logic        [23:0] step_mag;
	logic signed [24:0] step;
	logic signed [25:0] step_x;
	logic signed [25:0] b_wide;
	logic signed [25:0] s_wide;
	logic               moved;

	assign diff     = $signed({prev_yaw[15], prev_yaw}) - $signed({yaw[15], yaw});
	assign diff_neg = 17'd0 - diff;
	assign neg      = diff[16];
	assign mag      = neg ? diff_neg[15:0] : diff[15:0];
	assign moved    = prev_valid && (mag > {8'd0, cfg.dead_zone});

	always_comb begin
		case (mode)
			MODE_STANDING: gain = cfg.brightness_gain;
			MODE_LYING:    gain = cfg.hue_gain;
			default:       gain = cfg.saturation_gain;
		endcase
	end

	assign prod     = {8'd0, mag} * {16'd0, gain};
	assign step_mag = prod >> FRAC_BITS;
	assign step     = neg ? (25'sd0 - $signed({1'b0, step_mag})) : $signed({1'b0, step_mag});
	assign step_x   = {step[24], step};
	assign b_wide   = $signed({18'd0, levels.brightness}) - step_x;
	assign s_wide   = $signed({18'd0, levels.saturation}) + step_x;

	always_comb begin
		levels_next = levels;
		if (moved) begin
			case (mode)
				MODE_STANDING: begin
					if (b_wide < 26'sd0) begin
						levels_next.brightness = 8'd0;
					end else if (b_wide > 26'sd255) begin
						levels_next.brightness = 8'd255;
					end else begin
						levels_next.brightness = b_wide[7:0];
					end
				end
				MODE_LYING: begin
					levels_next.hue = levels.hue + step[7:0];
				end
				default: begin
					if (s_wide < 26'sd0) begin
						levels_next.saturation = 8'd0;
					end else if (s_wide > 26'sd255) begin
						levels_next.saturation = 8'd255;
					end else begin
						levels_next.saturation = s_wide[7:0];
					end
				end
			endcase
		end
	end

endmodule

@@ sv/tilt_rotation_light_control.sv @@
// Top level of the tilt and rotation light control.
// Depends on tlc_pkg, tlc_cfg, tlc_pose, tlc_update and the assertion macros.
//
//   channel  handshake                    payload
//   cfg      cfg_valid / cfg_ready        cfg_index, cfg_data
//   sample   sample_valid / sample_stall  tilt_x, tilt_y, yaw_angle, force_sleep
//   result   result_valid / result_stall  brightness_out .. sleep_request
//
// An accepted sample is captured in the sample stage and then moves into the result register;
// a new item can enter every cycle while sample_stall is low.
// The level state sits in the result register, so each item sees the previous one's update.
// Reset restores the register defaults and the initial levels; sleep stays latched until reset.
// A stalled result holds the sample stage, which in turn stalls the sample channel.
`include "tilt_rotation_light_control_macros.svh"

module tilt_rotation_light_control #(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [15:0] tilt_x,
	input  logic [15:0] tilt_y,
	input  logic [15:0] yaw_angle,
	input  logic        force_sleep,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  brightness_out,
	output logic [7:0]  hue_out,
	output logic [7:0]  saturation_out,
	output logic [1:0]  pose_mode,
	output logic        sleep_request
);
	import tlc_pkg::*;

	cfg_t        cfg;
	logic        advance;
	logic        valid_s1;
	logic [15:0] tilt_x_s1;
	logic [15:0] tilt_y_s1;
	logic [15:0] yaw_s1;
	logic        force_s1;
	mode_t       mode;
	levels_t     levels_q;
	levels_t     levels_next;
	mode_t       pose_q;
	logic [15:0] prev_yaw_q;
	logic        prev_valid_q;
	logic        dark_armed_q;
	logic [15:0] dark_ticks_q;
	logic [15:0] dark_ticks_inc;
	logic        dark_expired;
	logic        sleep_q;
	logic        result_valid_q;

	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;

	tlc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	tlc_pose u_pose (
		.tilt_x      (tilt_x_s1),
		.tilt_y      (tilt_y_s1),
		.level_limit (cfg.level_limit),
		.flip_limit  (cfg.flip_limit),
		.mode        (mode)
	);

	tlc_update #(
		.FRAC_BITS (ANGLE_FRAC_BITS)
	) u_update (
		.cfg         (cfg),
		.mode        (mode),
		.yaw         (yaw_s1),
		.prev_yaw    (prev_yaw_q),
		.prev_valid  (prev_valid_q),
		.levels      (levels_q),
		.levels_next (levels_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			tilt_x_s1 <= tilt_x;
			tilt_y_s1 <= tilt_y;
			yaw_s1    <= yaw_angle;
			force_s1  <= force_sleep;
		end
	end

	assign dark_ticks_inc = (dark_ticks_q == 16'hFFFF) ? dark_ticks_q : dark_ticks_q + 16'd1;
	assign dark_expired   = (levels_next.brightness == 8'd0) && dark_armed_q &&
		(dark_ticks_inc >= cfg.sleep_delay_ticks);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			levels_q       <= LEVELS_RESET;
			pose_q         <= MODE_STANDING;
			prev_yaw_q     <= 16'd0;
			prev_valid_q   <= 1'b0;
			dark_armed_q   <= 1'b0;
			dark_ticks_q   <= 16'd0;
			sleep_q        <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				levels_q     <= levels_next;
				pose_q       <= mode;
				prev_yaw_q   <= yaw_s1;
				prev_valid_q <= 1'b1;
				if (levels_next.brightness == 8'd0) begin
					if (!dark_armed_q) begin
						dark_armed_q <= 1'b1;
						dark_ticks_q <= 16'd0;
					end else begin
						dark_ticks_q <= dark_ticks_inc;
					end
				end else begin
					dark_armed_q <= 1'b0;
					dark_ticks_q <= 16'd0;
				end
				if (dark_expired || force_s1) begin
					sleep_q <= 1'b1;
				end
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign brightness_out = levels_q.brightness;
	assign hue_out        = levels_q.hue;
	assign saturation_out = levels_q.saturation;
	assign pose_mode      = pose_q;
	assign sleep_request  = sleep_q;

	`TLC_ASSERT_NEXT(a_sleep_latched, clk, arst_n, sleep_q, sleep_q)
	`TLC_ASSERT_IMPLY(a_stall_backpressure, clk, arst_n, valid_s1 && result_valid_q && result_stall, sample_stall)
	`TLC_ASSERT_IMPLY(a_disarmed_count_clear, clk, arst_n, !dark_armed_q, dark_ticks_q == 16'd0)

endmodule

@@ dv/tilt_rotation_light_control_checker.sv @@
// Checker for the tilt and rotation light control: watches the register, sample and result
// channels, predicts each result from its own copy of the state and compares it.
// Depends on tlc_pkg.
`timescale 1ns / 1ps

module tilt_rotation_light_control_checker
	import tlc_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        sample_valid,
	input  logic        sample_stall,
	input  logic [15:0] tilt_x,
	input  logic [15:0] tilt_y,
	input  logic [15:0] yaw_angle,
	input  logic        force_sleep,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [7:0]  brightness_out,
	input  logic [7:0]  hue_out,
	input  logic [7:0]  saturation_out,
	input  logic [1:0]  pose_mode,
	input  logic        sleep_request,
	output int          fail_count,
	output int          pending,
	output int          results_checked
);

	typedef struct packed {
		logic [7:0] brightness;
		logic [7:0] hue;
		logic [7:0] saturation;
		mode_t      mode;
		logic       sleep;
	} light_result_t;

	cfg_t                cfg;
	levels_t             lvl;
	logic signed [15:0]  last_yaw;
	logic                yaw_loaded;
	logic                dark_armed;
	logic [15:0]         dark_ticks;
	logic                sleep_latched;
	light_result_t       light_q[$];

	function automatic logic [7:0] clamp_level(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	task automatic report_failure(input string msg);
		if (fail_count < 10)
			$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic update_config(input cfg_idx_t idx, input logic [15:0] data);
		case (idx)
			REG_BRIGHTNESS_GAIN:   cfg.brightness_gain = data[7:0];
			REG_HUE_GAIN:          cfg.hue_gain = data[7:0];
			REG_SATURATION_GAIN:   cfg.saturation_gain = data[7:0];
			REG_DEAD_ZONE:         cfg.dead_zone = data[7:0];
			REG_LEVEL_LIMIT:       cfg.level_limit = data[11:0];
			REG_FLIP_LIMIT:        cfg.flip_limit = data[11:0];
			REG_SLEEP_DELAY_TICKS: cfg.sleep_delay_ticks = data;
			default: ;
		endcase
	endtask

	task automatic predict_light(input logic signed [15:0] tx, input logic signed [15:0] ty,
			input logic signed [15:0] yaw, input logic fs);
		int            ax, ay, d, dmag, gain, step;
		mode_t         mode;
		light_result_t r;
		ax = (tx < 0) ? -int'(tx) : int'(tx);
		ay = (ty < 0) ? -int'(ty) : int'(ty);
		if (ax < int'(cfg.level_limit) && ay < int'(cfg.level_limit))
			mode = MODE_UPSIDE_DOWN;
		else if (ax > int'(cfg.flip_limit) && ay < int'(cfg.level_limit))
			mode = MODE_STANDING;
		else
			mode = MODE_LYING;

		if (yaw_loaded) begin
			d = int'(last_yaw) - int'(yaw);
			dmag = (d < 0) ? -d : d;
			if (dmag > int'(cfg.dead_zone)) begin
				case (mode)
					MODE_STANDING: gain = int'(cfg.brightness_gain);
					MODE_LYING:    gain = int'(cfg.hue_gain);
					default:       gain = int'(cfg.saturation_gain);
				endcase
				step = (dmag * gain) >>> ANGLE_FRAC_BITS;
				if (d < 0)
					step = -step;
				case (mode)
					MODE_STANDING: lvl.brightness = clamp_level(int'(lvl.brightness) - step);
					MODE_LYING:    lvl.hue = 8'(int'(lvl.hue) + step);
					default:       lvl.saturation = clamp_level(int'(lvl.saturation) + step);
				endcase
			end
		end
		last_yaw = yaw;
		yaw_loaded = 1'b1;

		if (lvl.brightness == 8'd0) begin
			if (!dark_armed) begin
				dark_armed = 1'b1;
				dark_ticks = 16'd0;
			end else begin
				if (dark_ticks != 16'hFFFF)
					dark_ticks++;
				if (dark_ticks >= cfg.sleep_delay_ticks)
					sleep_latched = 1'b1;
			end
		end else begin
			dark_armed = 1'b0;
			dark_ticks = 16'd0;
		end
		if (fs)
			sleep_latched = 1'b1;

		r = '{brightness: lvl.brightness, hue: lvl.hue, saturation: lvl.saturation,
			mode: mode, sleep: sleep_latched};
		light_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		light_result_t want, got;
		if (!arst_n) begin
			cfg = CFG_RESET;
			lvl = LEVELS_RESET;
			last_yaw = '0;
			yaw_loaded = 1'b0;
			dark_armed = 1'b0;
			dark_ticks = '0;
			sleep_latched = 1'b0;
			light_q.delete();
			fail_count = 0;
			results_checked = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				update_config(cfg_index, cfg_data);
			if (result_valid && !result_stall) begin
				got = '{brightness: brightness_out, hue: hue_out, saturation: saturation_out,
					mode: pose_mode, sleep: sleep_request};
				if (light_q.size() == 0) begin
					report_failure($sformatf("result with no item waiting: b=%0d h=%0d s=%0d mode=%0d sleep=%0d",
						got.brightness, got.hue, got.saturation, got.mode, got.sleep));
				end else begin
					want = light_q.pop_front();
					if (got !== want)
						report_failure($sformatf({"result %0d mismatch: expected b=%0d h=%0d s=%0d ",
							"mode=%0d sleep=%0d, got b=%0d h=%0d s=%0d mode=%0d sleep=%0d"},
							results_checked, want.brightness, want.hue, want.saturation, want.mode,
							want.sleep, got.brightness, got.hue, got.saturation, got.mode, got.sleep));
				end
				results_checked++;
			end
			if (sample_valid && !sample_stall)
				predict_light(tilt_x, tilt_y, yaw_angle, force_sleep);
			pending <= light_q.size();
		end
	end

endmodule

@@ dv/tilt_rotation_light_control_tb.sv @@
// Testbench top for the tilt and rotation light control: drives register writes and orientation
// samples under several pacing modes and gives the verdict.
// Depends on tlc_pkg, the block and tilt_rotation_light_control_checker.
`timescale 1ns / 1ps

module tilt_rotation_light_control_tb;
	import tlc_pkg::*;

	localparam int       FRAC_BITS   = 4;
	localparam int       CYCLE_LIMIT = 400000;
	localparam int       HOLD_CYCLES = 200;
	localparam cfg_idx_t REG_UNUSED  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic [15:0] tilt_x = '0;
	logic [15:0] tilt_y = '0;
	logic [15:0] yaw_angle = '0;
	logic        force_sleep = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  brightness_out;
	logic [7:0]  hue_out;
	logic [7:0]  saturation_out;
	logic [1:0]  pose_mode;
	logic        sleep_request;

	int          fail_count;
	int          pending;
	int          results_checked;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_tag = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          settings_count = 0;
	int          cur_dead = 3;
	int          cur_level = 720;
	int          cur_flip = 2400;
	logic [15:0] last_yaw = '0;

	tilt_rotation_light_control #(
		.ANGLE_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.tilt_x(tilt_x),
		.tilt_y(tilt_y),
		.yaw_angle(yaw_angle),
		.force_sleep(force_sleep),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.brightness_out(brightness_out),
		.hue_out(hue_out),
		.saturation_out(saturation_out),
		.pose_mode(pose_mode),
		.sleep_request(sleep_request)
	);

	tilt_rotation_light_control_checker #(
		.ANGLE_FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.tilt_x(tilt_x),
		.tilt_y(tilt_y),
		.yaw_angle(yaw_angle),
		.force_sleep(force_sleep),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.brightness_out(brightness_out),
		.hue_out(hue_out),
		.saturation_out(saturation_out),
		.pose_mode(pose_mode),
		.sleep_request(sleep_request),
		.fail_count(fail_count),
		.pending(pending),
		.results_checked(results_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[tilt_rotation_light_control] ERROR");
			$finish;
		end
	end

	// A new hold request starts a long stall of the result channel.
	always @(posedge clk) begin
		if (hold_tag != hold_seen) begin
			hold_seen <= hold_tag;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [15:0] pick_angle(input int lo, input int hi);
		int m;
		if (lo < 0)
			lo = 0;
		if (hi > 32768)
			hi = 32768;
		if (hi < lo)
			hi = lo;
		m = $urandom_range(hi, lo);
		if (m == 32768)
			return 16'h8000;
		return $urandom_range(1) ? 16'(-m) : 16'(m);
	endfunction

	function automatic logic [15:0] next_yaw(input int drift);
		int k, delta;
		k = $urandom_range(99);
		if (k < 30)
			return 16'($urandom);
		if (k < 60)
			delta = $urandom_range(cur_dead + 2, (cur_dead > 0) ? cur_dead - 1 : 0);
		else
			delta = $urandom_range(300, 0);
		if (drift > 0 || (drift == 0 && $urandom_range(1)))
			return last_yaw - 16'(delta);
		return last_yaw + 16'(delta);
	endfunction

	task automatic send_sample(input int x, input int y, input int yaw, input bit fs);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			tilt_x <= 16'($urandom);
			yaw_angle <= 16'($urandom);
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		tilt_x <= 16'(x);
		tilt_y <= 16'(y);
		yaw_angle <= 16'(yaw);
		force_sleep <= fs;
		do
			@(posedge clk);
		while (sample_stall);
		last_yaw = 16'(yaw);
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Bits above each register's width carry junk that the block must drop.
	task automatic set_config(input int bg, input int hg, input int sg, input int dz,
			input int ll, input int fl, input int sd);
		drain_results();
		write_reg(REG_BRIGHTNESS_GAIN, {8'($urandom), 8'(bg)});
		write_reg(REG_HUE_GAIN, {8'($urandom), 8'(hg)});
		write_reg(REG_SATURATION_GAIN, {8'($urandom), 8'(sg)});
		write_reg(REG_DEAD_ZONE, {8'($urandom), 8'(dz)});
		write_reg(REG_LEVEL_LIMIT, {4'($urandom), 12'(ll)});
		write_reg(REG_FLIP_LIMIT, {4'($urandom), 12'(fl)});
		write_reg(REG_SLEEP_DELAY_TICKS, 16'(sd));
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
		cur_dead = dz;
		cur_level = ll;
		cur_flip = fl;
		settings_count++;
	endtask

	task automatic run_phase(input int n, input int idle_pct, input int stall_p,
			input int stand_pct, input int drift, input int force_pct, input int hold_at,
			input int drain_at);
		logic [15:0] x, y;
		int          k;
		send_idle_pct = idle_pct;
		stall_pct = stall_p;
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_tag++;
			if (i == drain_at)
				drain_results();
			if ($urandom_range(99) < stand_pct) begin
				x = pick_angle(cur_flip + 1, 32768);
				y = pick_angle(0, cur_level - 1);
			end else begin
				k = $urandom_range(99);
				if (k < 15)
					x = pick_angle(0, cur_level - 1);
				else if (k < 30)
					x = pick_angle(cur_level - 2, cur_level + 1);
				else if (k < 45)
					x = pick_angle(cur_flip - 1, cur_flip + 2);
				else if (k < 65)
					x = pick_angle(cur_flip + 1, 32768);
				else if (k < 80)
					x = pick_angle(cur_level, cur_flip);
				else
					x = 16'($urandom);
				k = $urandom_range(99);
				if (k < 50)
					y = pick_angle(0, cur_level - 1);
				else if (k < 65)
					y = pick_angle(cur_level - 2, cur_level + 1);
				else
					y = 16'($urandom);
			end
			send_sample(x, y, next_yaw(drift), $urandom_range(99) < force_pct);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset register values.
		send_sample(0, 0, 100, 0);
		send_sample(0, 0, 97, 0);
		send_sample(0, 0, 93, 0);
		send_sample(719, -719, 32767, 0);
		send_sample(-719, 719, -32768, 0);
		send_sample(720, 0, 32767, 0);
		send_sample(0, -720, 32667, 0);
		send_sample(2401, 0, -32768, 0);
		send_sample(2400, 719, -32768, 0);
		send_sample(-32768, 0, -32668, 0);
		send_sample(32767, 0, 32767, 0);
		send_sample(-2401, -719, 32767, 0);
		send_sample(2401, 720, 32767, 0);
		send_sample(-32768, -32768, -32768, 0);
		send_sample(0, 0, -32764, 0);
		send_sample(0, 0, -32761, 0);
		send_sample(3000, 0, -32768, 0);
		send_sample(3000, 0, 32767, 0);
		send_sample(3000, 0, -32768, 0);
		send_sample(3000, 0, -32768, 0);
		send_sample(3000, 0, -32768, 0);
		send_sample(32767, 32767, -32768, 0);

		set_config(255, 255, 255, 255, 4095, 4095, 65535);
		run_phase(300, 0, 0, 0, 0, 0, -1, -1);
		set_config(0, 0, 0, 0, 0, 0, 65535);
		run_phase(150, 73, 0, 0, 0, 0, -1, -1);
		set_config(12, 6, 12, 3, 720, 2400, 60000);
		run_phase(300, 0, 73, 10, 0, 0, -1, -1);
		begin
			int ll;
			ll = $urandom_range(1500, 200);
			set_config($urandom_range(255), $urandom_range(255), $urandom_range(255),
				$urandom_range(31), ll, $urandom_range(4095, ll), $urandom_range(65534, 40000));
			run_phase(300, 33, 33, 20, 0, 0, -1, 120);
			ll = $urandom_range(1500, 200);
			set_config($urandom_range(255), $urandom_range(255), $urandom_range(255),
				$urandom_range(31), ll, $urandom_range(4095, ll), $urandom_range(65534, 40000));
			run_phase(300, 0, 0, 20, 0, 0, 60, -1);
		end
		// Drive brightness down while standing so the timed sleep request latches.
		set_config($urandom_range(255, 16), $urandom_range(255), $urandom_range(255),
			$urandom_range(7), 720, 2400, $urandom_range(20, 5));
		run_phase(250, 73, 0, 80, 1, 0, -1, -1);
		set_config($urandom_range(255), $urandom_range(255), $urandom_range(255),
			$urandom_range(15), 720, 2400, 0);
		run_phase(250, 0, 73, 30, 0, 8, -1, -1);

		drain_results();
		repeat (10) @(posedge clk);
		$display("Checked %0d results over %0d register settings, with free running, idle sender,",
			results_checked, settings_count);
		$display("stalling receiver and mixed pacing, a long output hold-off, timed and forced sleep.");
		if (fail_count == 0 && pending == 0)
			$display("[tilt_rotation_light_control] OK");
		else
			$display("[tilt_rotation_light_control] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tlc_pkg.sv
sv/tlc_cfg.sv
sv/tlc_pose.sv
sv/tlc_update.sv
sv/tilt_rotation_light_control.sv
dv/tilt_rotation_light_control_checker.sv
dv/tilt_rotation_light_control_tb.sv
